// ===== src/dcls_pkg.sv =====
// ----------------------------------------------------------------------------
// dcls_pkg: shared types and constants for the display command list sequencer
// Phase codes, result kinds and the fixed constants of the list format.
// ----------------------------------------------------------------------------
package dcls_pkg;

    // Which byte of the command list is expected next
    typedef enum logic [2:0] {
        PH_COUNT  = 3'd0,
        PH_OPCODE = 3'd1,
        PH_ARGCNT = 3'd2,
        PH_ARG    = 3'd3,
        PH_DELAY  = 3'd4
    } t_phase;

    // Result kind codes
    typedef enum logic [1:0] {
        KIND_BUS   = 2'd0,
        KIND_DELAY = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned ArgW    = 7;
    localparam int unsigned DelayW  = 16;

    localparam logic [ByteW-1:0]  LongMark   = 8'd255;
    localparam logic [DelayW-1:0] LongReset  = 16'd500;

endpackage

// ===== src/display_command_list_sequencer.sv =====
// Each result is registered and is valid in the cycle after the list byte that causes it.
// Throughput: one list byte per cycle; the output register frees itself in
// the same cycle it is taken, so backpressure only stalls on a full register.
// Reset (synchronous, active low): expects a command count byte, no result
// pending, long delay register at 500 ms.
// ----------------------------------------------------------------------------
// display_command_list_sequencer: display init command list walker
// Turns a command list, one byte per beat, into bus bytes, delay requests
// and end markers, flagging the last result of each list.
// ----------------------------------------------------------------------------
module display_command_list_sequencer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [dcls_pkg::DelayW-1:0] i_cfg_data,
    // list byte input
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [dcls_pkg::ByteW-1:0]  i_list_byte,
    // result output
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_kind,
    output logic [dcls_pkg::ByteW-1:0]  o_out_byte,
    output logic                        o_is_data,
    output logic [dcls_pkg::DelayW-1:0] o_wait_ms,
    output logic                        o_list_done
);
    import dcls_pkg::*;

    // state
    t_phase            r_phase,     n_phase;
    logic [ByteW-1:0]  r_cmds_left, n_cmds_left;
    logic [ArgW-1:0]   r_args_left, n_args_left;
    logic              r_dly_pend,  n_dly_pend;
    logic [ByteW-1:0]  r_held_op,   n_held_op;
    logic [DelayW-1:0] r_long_delay;

    // result register
    logic              r_out_valid;
    t_kind             r_kind,      n_kind;
    logic [ByteW-1:0]  r_out_byte,  n_out_byte;
    logic              r_is_data,   n_is_data;
    logic [DelayW-1:0] r_wait_ms,   n_wait_ms;
    logic              r_list_done, n_list_done;
    logic              n_emit;

    logic              in_accept;
    logic              last_cmd;
    logic [ByteW-1:0]  cmds_dec;
    logic [ArgW-1:0]   args_dec;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign last_cmd    = (r_cmds_left == ByteW'(1));
    assign cmds_dec    = r_cmds_left - ByteW'(1);
    assign args_dec    = r_args_left - ArgW'(1);

    // long delay register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_delay <= LongReset;
        end else if (i_cfg_valid) begin
            r_long_delay <= i_cfg_data;
        end
    end

    // next state and result for the byte on the input
    always_comb begin
        n_phase     = r_phase;
        n_cmds_left = r_cmds_left;
        n_args_left = r_args_left;
        n_dly_pend  = r_dly_pend;
        n_held_op   = r_held_op;
        n_emit      = 1'b0;
        n_kind      = KIND_BUS;
        n_out_byte  = '0;
        n_is_data   = 1'b0;
        n_wait_ms   = '0;
        n_list_done = 1'b0;
        unique case (r_phase)
            PH_OPCODE: begin
                n_held_op = i_list_byte;
                n_phase   = PH_ARGCNT;
            end
            PH_ARGCNT: begin
                n_args_left = i_list_byte[ArgW-1:0];
                n_dly_pend  = i_list_byte[ByteW-1];
                n_emit      = 1'b1;
                n_out_byte  = r_held_op;
                n_list_done = (i_list_byte == '0) && last_cmd;
                if (i_list_byte[ArgW-1:0] != '0) begin
                    n_phase = PH_ARG;
                end else if (i_list_byte[ByteW-1]) begin
                    n_phase = PH_DELAY;
                end else begin
                    n_cmds_left = cmds_dec;
                    n_phase     = (cmds_dec == '0) ? PH_COUNT : PH_OPCODE;
                end
            end
            PH_ARG: begin
                n_args_left = args_dec;
                n_emit      = 1'b1;
                n_out_byte  = i_list_byte;
                n_is_data   = 1'b1;
                n_list_done = (args_dec == '0) && !r_dly_pend && last_cmd;
                if (args_dec == '0) begin
                    if (r_dly_pend) begin
                        n_phase = PH_DELAY;
                    end else begin
                        n_cmds_left = cmds_dec;
                        n_phase     = (cmds_dec == '0) ? PH_COUNT : PH_OPCODE;
                    end
                end
            end
            PH_DELAY: begin
                n_emit      = 1'b1;
                n_kind      = KIND_DELAY;
                n_wait_ms   = (i_list_byte == LongMark) ? r_long_delay
                                                        : DelayW'(i_list_byte);
                n_list_done = last_cmd;
                n_dly_pend  = 1'b0;
                n_cmds_left = cmds_dec;
                n_phase     = (cmds_dec == '0) ? PH_COUNT : PH_OPCODE;
            end
            default: begin
                // count byte; a zero count is a list of its own
                n_args_left = '0;
                n_dly_pend  = 1'b0;
                n_cmds_left = i_list_byte;
                if (i_list_byte == '0) begin
                    n_phase     = PH_COUNT;
                    n_emit      = 1'b1;
                    n_kind      = KIND_END;
                    n_list_done = 1'b1;
                end else begin
                    n_phase = PH_OPCODE;
                end
            end
        endcase
    end

    // state registers, advanced per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_COUNT;
            r_cmds_left <= '0;
            r_args_left <= '0;
            r_dly_pend  <= 1'b0;
            r_held_op   <= '0;
        end else if (in_accept) begin
            r_phase     <= n_phase;
            r_cmds_left <= n_cmds_left;
            r_args_left <= n_args_left;
            r_dly_pend  <= n_dly_pend;
            r_held_op   <= n_held_op;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= n_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_accept && n_emit) begin
            r_kind      <= n_kind;
            r_out_byte  <= n_out_byte;
            r_is_data   <= n_is_data;
            r_wait_ms   <= n_wait_ms;
            r_list_done <= n_list_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_out_byte  = r_out_byte;
    assign o_is_data   = r_is_data;
    assign o_wait_ms   = r_wait_ms;
    assign o_list_done = r_list_done;

    // a zero count byte yields an end marker next cycle
    a_zero_count_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (r_phase == PH_COUNT) && (i_list_byte == '0)
        |=> o_out_valid && (o_kind == KIND_END) && o_list_done)
        else $error("zero count did not give end marker");

    // data flag only on bus bytes
    a_data_is_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_data |-> (o_kind == KIND_BUS))
        else $error("data flag on a non-bus result");

    // an opcode byte never produces a result
    a_opcode_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (r_phase == PH_OPCODE) |=> !o_out_valid)
        else $error("opcode byte produced a result");

    // finishing the last command returns to the count phase
    a_done_to_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && n_emit && n_list_done |=> (r_phase == PH_COUNT))
        else $error("list done without returning to count phase");

endmodule
